/* hdl/skst_pkg.sv */
`default_nettype none

package skst_pkg;

    // Default sizing of the table.
    localparam int CAPACITY_DEF       = 1024;
    localparam int MAX_ALIGNMENTS_DEF = 32;

    // Field widths of the item and result channels.
    localparam int W_OP      = 2;
    localparam int W_POS_I   = 12;
    localparam int W_POS_J   = 20;
    localparam int W_ALN     = 5;
    localparam int W_RIDX    = 10;
    localparam int W_STATUS  = 3;
    localparam int W_KEY     = W_POS_I + W_POS_J;
    localparam int W_SUP     = 32;
    localparam int W_POSN    = 10;
    localparam int W_TOTAL   = 11;

    // Operation codes.
    localparam logic [W_OP-1:0] OP_INSERT = 2'd0;
    localparam logic [W_OP-1:0] OP_READ   = 2'd1;
    localparam logic [W_OP-1:0] OP_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [W_STATUS-1:0] ST_INSERTED = 3'd0;
    localparam logic [W_STATUS-1:0] ST_UPDATED  = 3'd1;
    localparam logic [W_STATUS-1:0] ST_FULL     = 3'd2;
    localparam logic [W_STATUS-1:0] ST_READ_OK  = 3'd3;
    localparam logic [W_STATUS-1:0] ST_READ_OOR = 3'd4;
    localparam logic [W_STATUS-1:0] ST_CLEARED  = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;         // capture the accepted item
        logic                clear;        // empty the table
        logic                probe_rd;     // read the entry at the search midpoint
        logic                cmp;          // narrow the search window
        logic                upd_wr;       // write back the updated support mask
        logic                shift_start;  // read the top entry, pointer to fill count
        logic                shift_step;   // move one entry up by one place
        logic                ins_wr;       // store the new entry, bump fill count
        logic                rd_issue;     // read the entry at the read index
        logic                res_set;      // stage a result
        logic [W_STATUS-1:0] res_kind;
        logic                out_load;     // move the staged result to the output
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [W_OP-1:0] op;
        logic            search_done;
        logic            cmp_eq;
        logic            full;
        logic            need_shift;
        logic            shift_more;
        logic            rd_in_range;
        logic            out_busy;
    } t_sts;

endpackage

`default_nettype wire

/* hdl/skst_if.sv */
`default_nettype none

interface skst_in_if;
    import skst_pkg::*;

    logic                valid;
    logic                ready;
    logic [W_OP-1:0]     opcode;
    logic [W_POS_I-1:0]  pos_i;
    logic [W_POS_J-1:0]  pos_j;
    logic [W_ALN-1:0]    aln_index;
    logic [W_RIDX-1:0]   read_index;

    modport source (
        output valid, opcode, pos_i, pos_j, aln_index, read_index,
        input  ready
    );
    modport sink (
        input  valid, opcode, pos_i, pos_j, aln_index, read_index,
        output ready
    );
endinterface

interface skst_out_if;
    import skst_pkg::*;

    logic                valid;
    logic                ready;
    logic [W_STATUS-1:0] status;
    logic [W_KEY-1:0]    entry_key;
    logic [W_SUP-1:0]    entry_support;
    logic [W_POSN-1:0]   entry_position;
    logic [W_TOTAL-1:0]  entry_total;

    modport source (
        output valid, status, entry_key, entry_support, entry_position, entry_total,
        input  ready
    );
    modport sink (
        input  valid, status, entry_key, entry_support, entry_position, entry_total,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/sorted_key_support_table_core.sv */
// Channel   Dir   Transfer when          Payload
// i_in      in    valid && ready         opcode, pos_i, pos_j, aln_index, read_index
// o_out     out   valid && ready         status, entry_key, entry_support,
//                                        entry_position, entry_total
//
// One item is in work at a time. A search probe reads the window midpoint and
// then narrows the window, with at most clog2(CAPACITY+1) probes. A new key is
// written at the top of the table, or after the entries above its place move
// up, one per cycle; a found key has its support mask updated in place. Reads
// and clears stage their result. The table memory does one read and one write a
// cycle. Synchronous active-low reset empties the table; the memory is not swept.
// A result waits in the output register while the next item is taken in; that
// item stalls in its last cycle until the output drains.
`default_nettype none

module sorted_key_support_table_core #(
    parameter int CAPACITY       = skst_pkg::CAPACITY_DEF,
    parameter int MAX_ALIGNMENTS = skst_pkg::MAX_ALIGNMENTS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    skst_in_if.sink     i_in,
    skst_out_if.source  o_out
);
    import skst_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    skst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(w_in_ready),
        .o_cmd     (w_cmd),
        .i_sts     (w_sts)
    );

    skst_dp #(
        .CAPACITY      (CAPACITY),
        .MAX_ALIGNMENTS(MAX_ALIGNMENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (i_in.opcode),
        .i_pos_i         (i_in.pos_i),
        .i_pos_j         (i_in.pos_j),
        .i_aln_index     (i_in.aln_index),
        .i_read_index    (i_in.read_index),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_status        (o_out.status),
        .o_entry_key     (o_out.entry_key),
        .o_entry_support (o_out.entry_support),
        .o_entry_position(o_out.entry_position),
        .o_entry_total   (o_out.entry_total)
    );

    assign i_in.ready = w_in_ready;

    // Once an item is taken, no other is taken until it has finished.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second item accepted while one is in work");

    // A result is never moved to the output while the previous one waits.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(o_out.valid && !o_out.ready))
        else $error("pending result overwritten");

    // A rejected insert reports an empty mask.
    a_full_empty_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_FULL)) |-> (o_out.entry_support == '0))
        else $error("full status with nonzero support");
endmodule

`default_nettype wire

/* hdl/skst_ram.sv */
`default_nettype none

module skst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

/* hdl/skst_ctrl.sv */
`default_nettype none

module skst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output      logic          o_in_ready,
    output      skst_pkg::t_cmd o_cmd,
    input  wire skst_pkg::t_sts i_sts
);
    import skst_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_PROBE    = 4'd2;
    localparam logic [3:0] S_CMP      = 4'd3;
    localparam logic [3:0] S_SHIFT    = 4'd4;
    localparam logic [3:0] S_INSERT   = 4'd5;
    localparam logic [3:0] S_RDWAIT   = 4'd6;
    localparam logic [3:0] S_RESP     = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_INSERT: n_state = S_PROBE;
                    OP_READ: begin
                        if (i_sts.rd_in_range) begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_RDWAIT;
                        end else begin
                            o_cmd.res_set  = 1'b1;
                            o_cmd.res_kind = ST_READ_OOR;
                            n_state        = S_RESP;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clear    = 1'b1;
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = ST_CLEARED;
                        n_state        = S_RESP;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_PROBE: begin
                if (i_sts.search_done) begin
                    if (i_sts.full) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = ST_FULL;
                        n_state        = S_RESP;
                    end else if (i_sts.need_shift) begin
                        o_cmd.shift_start = 1'b1;
                        n_state           = S_SHIFT;
                    end else begin
                        o_cmd.ins_wr   = 1'b1;
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = ST_INSERTED;
                        n_state        = S_RESP;
                    end
                end else begin
                    o_cmd.probe_rd = 1'b1;
                    n_state        = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.cmp_eq) begin
                    o_cmd.upd_wr   = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = ST_UPDATED;
                    n_state        = S_RESP;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (!i_sts.shift_more) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.ins_wr   = 1'b1;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_kind = ST_INSERTED;
                n_state        = S_RESP;
            end
            S_RDWAIT: begin
                o_cmd.res_set  = 1'b1;
                o_cmd.res_kind = ST_READ_OK;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

`default_nettype wire

/* hdl/skst_dp.sv */
`default_nettype none

module skst_dp #(
    parameter int CAPACITY       = 1024,
    parameter int MAX_ALIGNMENTS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [skst_pkg::W_OP-1:0]     i_opcode,
    input  wire logic [skst_pkg::W_POS_I-1:0]  i_pos_i,
    input  wire logic [skst_pkg::W_POS_J-1:0]  i_pos_j,
    input  wire logic [skst_pkg::W_ALN-1:0]    i_aln_index,
    input  wire logic [skst_pkg::W_RIDX-1:0]   i_read_index,
    input  wire skst_pkg::t_cmd                i_cmd,
    output      skst_pkg::t_sts                o_sts,
    input  wire logic                          i_out_ready,
    output      logic                          o_out_valid,
    output      logic [skst_pkg::W_STATUS-1:0] o_status,
    output      logic [skst_pkg::W_KEY-1:0]    o_entry_key,
    output      logic [skst_pkg::W_SUP-1:0]    o_entry_support,
    output      logic [skst_pkg::W_POSN-1:0]   o_entry_position,
    output      logic [skst_pkg::W_TOTAL-1:0]  o_entry_total
);
    import skst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int DW = W_KEY + W_SUP;

    // Captured item.
    logic [W_OP-1:0]   r_op;
    logic [W_KEY-1:0]  r_key;
    logic [W_SUP-1:0]  r_aln_bit;
    logic [W_RIDX-1:0] r_ridx;

    // Search window, shift pointer and fill count.
    logic [FW-1:0] r_lo;
    logic [FW-1:0] r_hi;
    logic [AW-1:0] r_ptr;
    logic [FW-1:0] r_fill;

    // Staged result and output register.
    logic [W_STATUS-1:0] r_res_status;
    logic [W_KEY-1:0]    r_res_key;
    logic [W_SUP-1:0]    r_res_sup;
    logic [W_POSN-1:0]   r_res_pos;
    logic [W_TOTAL-1:0]  r_res_total;
    logic [W_KEY-1:0]    n_res_key;
    logic [W_SUP-1:0]    n_res_sup;
    logic [W_POSN-1:0]   n_res_pos;
    logic [W_TOTAL-1:0]  n_res_total;
    logic                r_out_valid;
    logic [W_STATUS-1:0] r_out_status;
    logic [W_KEY-1:0]    r_out_key;
    logic [W_SUP-1:0]    r_out_sup;
    logic [W_POSN-1:0]   r_out_pos;
    logic [W_TOTAL-1:0]  r_out_total;

    logic [W_KEY-1:0]  w_in_key;
    logic [W_SUP-1:0]  w_in_bit;
    logic [FW:0]       w_sum;
    logic [AW-1:0]     w_mid;
    logic [DW-1:0]     w_rdata;
    logic [W_KEY-1:0]  w_rd_key;
    logic [W_SUP-1:0]  w_rd_sup;
    logic [W_SUP-1:0]  w_upd_sup;
    logic [FW:0]       w_lo_inc;
    logic [FW-1:0]     w_fill_inc;
    logic [FW+W_RIDX-1:0] w_ridx_ext;
    logic [FW+W_RIDX-1:0] w_fill_ext_r;
    logic [AW+W_RIDX-1:0] w_ridx_addr;
    logic [FW+W_POSN-1:0] w_lo_posn;
    logic [AW+W_POSN-1:0] w_mid_posn;
    logic [FW+W_TOTAL-1:0] w_fill_tot;
    logic [FW+W_TOTAL-1:0] w_finc_tot;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;

    assign w_in_key = {i_pos_i, i_pos_j};
    assign w_in_bit = ({{(32 - W_ALN){1'b0}}, i_aln_index} < MAX_ALIGNMENTS)
                      ? (W_SUP'(1) << i_aln_index) : '0;

    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum[AW:1];
    assign w_rd_key   = w_rdata[DW-1:W_SUP];
    assign w_rd_sup   = w_rdata[W_SUP-1:0];
    assign w_upd_sup  = w_rd_sup | r_aln_bit;
    assign w_lo_inc   = {1'b0, r_lo} + 1'b1;
    assign w_fill_inc = r_fill + 1'b1;

    // Zero-extended copies, so the fixed field widths work at any capacity.
    assign w_ridx_ext   = {{FW{1'b0}}, r_ridx};
    assign w_fill_ext_r = {{W_RIDX{1'b0}}, r_fill};
    assign w_ridx_addr  = {{AW{1'b0}}, r_ridx};
    assign w_lo_posn    = {{W_POSN{1'b0}}, r_lo};
    assign w_mid_posn   = {{W_POSN{1'b0}}, w_mid};
    assign w_fill_tot   = {{W_TOTAL{1'b0}}, r_fill};
    assign w_finc_tot   = {{W_TOTAL{1'b0}}, w_fill_inc};

    always_comb begin
        o_sts             = '0;
        o_sts.op          = r_op;
        o_sts.search_done = (r_lo >= r_hi);
        o_sts.cmp_eq      = (w_rd_key == r_key);
        o_sts.full        = (r_fill == FW'(CAPACITY));
        o_sts.need_shift  = (r_fill > r_lo);
        o_sts.shift_more  = ({1'b0, {(FW - AW){1'b0}}, r_ptr} > w_lo_inc);
        o_sts.rd_in_range = (w_ridx_ext < w_fill_ext_r);
        o_sts.out_busy    = r_out_valid && !i_out_ready;
    end

    // Result fields for the kind being staged.
    always_comb begin
        n_res_key   = r_key;
        n_res_sup   = '0;
        n_res_pos   = w_lo_posn[W_POSN-1:0];
        n_res_total = w_fill_tot[W_TOTAL-1:0];
        case (i_cmd.res_kind)
            ST_INSERTED: begin
                n_res_sup   = r_aln_bit;
                n_res_total = w_finc_tot[W_TOTAL-1:0];
            end
            ST_UPDATED: begin
                n_res_sup = w_upd_sup;
                n_res_pos = w_mid_posn[W_POSN-1:0];
            end
            ST_READ_OK: begin
                n_res_key = w_rd_key;
                n_res_sup = w_rd_sup;
                n_res_pos = r_ridx;
            end
            ST_READ_OOR: begin
                n_res_key = '0;
                n_res_pos = r_ridx;
            end
            ST_CLEARED: begin
                n_res_key   = '0;
                n_res_pos   = '0;
                n_res_total = '0;
            end
            default: ;
        endcase
    end

    // One read port and one write port: one read and one write per cycle at most.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_lo[AW-1:0];
        w_wdata = {r_key, r_aln_bit};
        w_re    = 1'b0;
        w_raddr = w_mid;
        if (i_cmd.upd_wr) begin
            w_we    = 1'b1;
            w_waddr = w_mid;
            w_wdata = {r_key, w_upd_sup};
        end else if (i_cmd.shift_step) begin
            w_we    = 1'b1;
            w_waddr = r_ptr;
            w_wdata = w_rdata;
        end else if (i_cmd.ins_wr) begin
            w_we = 1'b1;
        end

        if (i_cmd.probe_rd) begin
            w_re = 1'b1;
        end else if (i_cmd.shift_start) begin
            w_re    = 1'b1;
            w_raddr = r_fill[AW-1:0] - 1'b1;
        end else if (i_cmd.shift_step) begin
            // The next source entry sits two below the one being written.
            w_re    = o_sts.shift_more;
            w_raddr = r_ptr - AW'(2);
        end else if (i_cmd.rd_issue) begin
            w_re    = 1'b1;
            w_raddr = w_ridx_addr[AW-1:0];
        end
    end

    skst_ram #(
        .WIDTH(DW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_opcode;
            r_key     <= w_in_key;
            r_aln_bit <= w_in_bit;
            r_ridx    <= i_read_index;
            r_lo      <= '0;
            r_hi      <= r_fill;
        end else if (i_cmd.cmp && !o_sts.cmp_eq) begin
            if (w_rd_key < r_key) begin
                r_lo <= FW'(w_mid) + 1'b1;
            end else begin
                r_hi <= FW'(w_mid);
            end
        end

        if (i_cmd.shift_start) begin
            r_ptr <= r_fill[AW-1:0];
        end else if (i_cmd.shift_step) begin
            r_ptr <= r_ptr - 1'b1;
        end

        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_kind;
            r_res_key    <= n_res_key;
            r_res_sup    <= n_res_sup;
            r_res_pos    <= n_res_pos;
            r_res_total  <= n_res_total;
        end

        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_key    <= r_res_key;
            r_out_sup    <= r_res_sup;
            r_out_pos    <= r_res_pos;
            r_out_total  <= r_res_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_fill <= '0;
            end else if (i_cmd.ins_wr) begin
                r_fill <= w_fill_inc;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_entry_key      = r_out_key;
    assign o_entry_support  = r_out_sup;
    assign o_entry_position = r_out_pos;
    assign o_entry_total    = r_out_total;
endmodule

`default_nettype wire
